/* hw/rtl/assert_macros.svh */
// assertion macros included by the quicksort block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/qsort_pkg.sv */
// types, sizes and sequencer states of the quicksort block
package qsort_pkg;

   localparam int MAX_ITEMS   = 64;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int STACK_PAIRS = 32;
   localparam int SPI_W       = $clog2(STACK_PAIRS);

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic [CNT_W-1:0]             cnt_type;
   typedef logic signed [IDX_W+1:0]      pos_type;
   typedef logic [SPI_W:0]               sp_type;
   typedef logic [SPI_W-1:0]             spi_type;

   typedef struct packed {
      idx_type lo;
      idx_type hi;
   } range_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_POP,
      ST_RANGE,
      ST_PIVOT,
      ST_SCAN_J,
      ST_SCAN_I,
      ST_SWAP,
      ST_PART,
      ST_PUSH2,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } state_type;

   // zero-extend a store index into the signed scan position
   function automatic pos_type to_pos(idx_type v);
      return pos_type'({2'b00, v});
   endfunction

endpackage

/* hw/rtl/quicksort_hoare_mid_pivot.sv */
// quicksort block: load, hoare partition around the middle element, emit in order
//
//  channel | direction | ports                                   | beat
//  req     | in        | req_valid/ready, value, last_in         | one value to sort
//  rsp     | out       | rsp_valid/ready, sorted_value, last_out,| one sorted value
//          |           | overflowed                              |
//
// loading accepts one beat per cycle; req_ready is low from the last beat until the run is out.
// sorting shares the single store port: each scan step reads one item, each swap writes the
//   pair in ST_SCAN_I and ST_SWAP, and each partition runs ST_POP, ST_RANGE, ST_PIVOT, ST_PART.
// emission steps through ST_EMIT_RD, ST_EMIT_LD and ST_EMIT_OUT for each beat, waiting while rsp_ready is low.
// synchronous reset clears control state only; store and range stack need no clearing.
// capacity is 64 values; further beats are dropped and flag the run as overflowed.
`include "assert_macros.svh"

module quicksort_hoare_mid_pivot (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [qsort_pkg::DATA_WIDTH-1:0] req_value,
   input  logic                        req_last_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [qsort_pkg::DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                        rsp_last_out,
   output logic                        rsp_overflowed
);

   qsort_pkg::state_type state_ff, state_in;

   // control registers
   qsort_pkg::cnt_type count_ff, count_in;
   qsort_pkg::sp_type  sp_ff, sp_in;
   logic               ovf_ff, ovf_in;
   qsort_pkg::idx_type k_ff, k_in;
   logic               out_valid_ff, out_valid_in;

   // partition registers
   qsort_pkg::idx_type  lo_ff, lo_in, hi_ff, hi_in;
   qsort_pkg::pos_type  i_ff, i_in, j_ff, j_in;
   qsort_pkg::data_type piv_ff, piv_in, jval_ff, jval_in, out_data_ff, out_data_in;

   // item store
   qsort_pkg::data_type store [qsort_pkg::MAX_ITEMS];
   qsort_pkg::data_type st_rd_ff;
   logic                st_we;
   qsort_pkg::idx_type  st_waddr, st_raddr;
   qsort_pkg::data_type st_wdata;

   // range stack
   qsort_pkg::range_type stack [qsort_pkg::STACK_PAIRS];
   qsort_pkg::range_type stk_rd_ff;
   logic                 stk_we;
   qsort_pkg::spi_type   stk_waddr, stk_raddr;
   qsort_pkg::range_type stk_wdata;

   // shared decisions
   logic                accept_in, accept_out, out_last;
   logic                range_bad, j_go, i_go, i_le_j, swap_more;
   logic                has_a, has_b, a_bigger, push_ok;
   qsort_pkg::pos_type  lo_pos, hi_pos, i_inc, j_dec, size_a, size_b;
   logic [qsort_pkg::IDX_W:0] mid_sum;
   qsort_pkg::sp_type   sp_dec;
   qsort_pkg::cnt_type  n_last;

   assign accept_in  = req_valid && req_ready;
   assign accept_out = rsp_valid && rsp_ready;
   assign n_last     = count_ff - qsort_pkg::cnt_type'(1);
   assign out_last   = qsort_pkg::cnt_type'(k_ff) == n_last;

   assign lo_pos  = qsort_pkg::to_pos(lo_ff);
   assign hi_pos  = qsort_pkg::to_pos(hi_ff);
   assign i_inc   = i_ff + qsort_pkg::pos_type'(1);
   assign j_dec   = j_ff - qsort_pkg::pos_type'(1);
   assign mid_sum = {1'b0, stk_rd_ff.lo} + {1'b0, stk_rd_ff.hi};
   assign sp_dec  = sp_ff - qsort_pkg::sp_type'(1);

   assign range_bad = (qsort_pkg::cnt_type'(stk_rd_ff.lo) >= count_ff) ||
                      (qsort_pkg::cnt_type'(stk_rd_ff.hi) >= count_ff) ||
                      (stk_rd_ff.lo >= stk_rd_ff.hi);
   assign j_go      = (j_ff > lo_pos) && (st_rd_ff > piv_ff);
   assign i_go      = (i_ff < hi_pos) && (st_rd_ff < piv_ff);
   assign i_le_j    = i_ff <= j_ff;
   assign swap_more = i_inc <= j_dec;
   assign has_a     = lo_pos < j_ff;
   assign has_b     = i_ff < hi_pos;
   assign size_a    = j_ff - lo_pos;
   assign size_b    = hi_pos - i_ff;
   assign a_bigger  = size_a >= size_b;
   assign push_ok   = sp_ff < qsort_pkg::sp_type'(qsort_pkg::STACK_PAIRS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qsort_pkg::ST_LOAD: begin
            if (accept_in && req_last_in) state_in = qsort_pkg::ST_START;
         end
         qsort_pkg::ST_START: begin
            priority if (count_ff == '0)                      state_in = qsort_pkg::ST_LOAD;
            else if (count_ff == qsort_pkg::cnt_type'(1))     state_in = qsort_pkg::ST_EMIT_RD;
            else                                              state_in = qsort_pkg::ST_POP;
         end
         qsort_pkg::ST_POP: begin
            state_in = (sp_ff == '0) ? qsort_pkg::ST_EMIT_RD : qsort_pkg::ST_RANGE;
         end
         qsort_pkg::ST_RANGE: begin
            state_in = range_bad ? qsort_pkg::ST_POP : qsort_pkg::ST_PIVOT;
         end
         qsort_pkg::ST_PIVOT: state_in = qsort_pkg::ST_SCAN_J;
         qsort_pkg::ST_SCAN_J: begin
            if (!j_go) state_in = qsort_pkg::ST_SCAN_I;
         end
         qsort_pkg::ST_SCAN_I: begin
            priority if (i_go) state_in = qsort_pkg::ST_SCAN_I;
            else if (i_le_j)   state_in = qsort_pkg::ST_SWAP;
            else               state_in = qsort_pkg::ST_PART;
         end
         qsort_pkg::ST_SWAP: begin
            state_in = swap_more ? qsort_pkg::ST_SCAN_J : qsort_pkg::ST_PART;
         end
         qsort_pkg::ST_PART: begin
            state_in = (has_a && has_b) ? qsort_pkg::ST_PUSH2 : qsort_pkg::ST_POP;
         end
         qsort_pkg::ST_PUSH2:   state_in = qsort_pkg::ST_POP;
         qsort_pkg::ST_EMIT_RD: state_in = qsort_pkg::ST_EMIT_LD;
         qsort_pkg::ST_EMIT_LD: state_in = qsort_pkg::ST_EMIT_OUT;
         qsort_pkg::ST_EMIT_OUT: begin
            if (accept_out) state_in = out_last ? qsort_pkg::ST_LOAD : qsort_pkg::ST_EMIT_RD;
         end
         default: state_in = qsort_pkg::ST_LOAD;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in     = count_ff;
      sp_in        = sp_ff;
      ovf_in       = ovf_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      piv_in       = piv_ff;
      jval_in      = jval_ff;
      out_data_in  = out_data_ff;
      st_we        = 1'b0;
      st_waddr     = count_ff[qsort_pkg::IDX_W-1:0];
      st_wdata     = req_value;
      st_raddr     = j_ff[qsort_pkg::IDX_W-1:0];
      stk_we       = 1'b0;
      stk_waddr    = sp_ff[qsort_pkg::SPI_W-1:0];
      stk_wdata    = '{lo: lo_ff, hi: hi_ff};
      stk_raddr    = sp_dec[qsort_pkg::SPI_W-1:0];
      unique case (state_ff)
         qsort_pkg::ST_LOAD: begin
            if (accept_in) begin
               if (count_ff < qsort_pkg::cnt_type'(qsort_pkg::MAX_ITEMS)) begin
                  st_we    = 1'b1;
                  count_in = count_ff + qsort_pkg::cnt_type'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         qsort_pkg::ST_START: begin
            if (count_ff == '0) begin
               ovf_in = 1'b0;
               sp_in  = '0;
            end else if (count_ff != qsort_pkg::cnt_type'(1)) begin
               stk_we    = 1'b1;
               stk_wdata = '{lo: '0, hi: n_last[qsort_pkg::IDX_W-1:0]};
               sp_in     = sp_ff + qsort_pkg::sp_type'(1);
            end
         end
         qsort_pkg::ST_POP: begin
            if (sp_ff != '0) sp_in = sp_dec;
         end
         qsort_pkg::ST_RANGE: begin
            lo_in    = stk_rd_ff.lo;
            hi_in    = stk_rd_ff.hi;
            i_in     = qsort_pkg::to_pos(stk_rd_ff.lo);
            j_in     = qsort_pkg::to_pos(stk_rd_ff.hi);
            st_raddr = mid_sum[qsort_pkg::IDX_W:1];
         end
         qsort_pkg::ST_PIVOT: begin
            piv_in   = st_rd_ff;
            st_raddr = j_ff[qsort_pkg::IDX_W-1:0];
         end
         qsort_pkg::ST_SCAN_J: begin
            if (j_go) begin
               j_in     = j_dec;
               st_raddr = j_dec[qsort_pkg::IDX_W-1:0];
            end else begin
               jval_in  = st_rd_ff;
               st_raddr = i_ff[qsort_pkg::IDX_W-1:0];
            end
         end
         qsort_pkg::ST_SCAN_I: begin
            if (i_go) begin
               i_in     = i_inc;
               st_raddr = i_inc[qsort_pkg::IDX_W-1:0];
            end else if (i_le_j) begin
               st_we    = 1'b1;
               st_waddr = j_ff[qsort_pkg::IDX_W-1:0];
               st_wdata = st_rd_ff;
            end
         end
         qsort_pkg::ST_SWAP: begin
            st_we    = 1'b1;
            st_waddr = i_ff[qsort_pkg::IDX_W-1:0];
            st_wdata = jval_ff;
            i_in     = i_inc;
            j_in     = j_dec;
            st_raddr = j_dec[qsort_pkg::IDX_W-1:0];
         end
         qsort_pkg::ST_PART: begin
            // larger side goes first so the smaller one is popped next
            if (has_a && (!has_b || a_bigger)) begin
               stk_wdata = '{lo: lo_ff, hi: j_ff[qsort_pkg::IDX_W-1:0]};
            end else begin
               stk_wdata = '{lo: i_ff[qsort_pkg::IDX_W-1:0], hi: hi_ff};
            end
            if ((has_a || has_b) && push_ok) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + qsort_pkg::sp_type'(1);
            end
         end
         qsort_pkg::ST_PUSH2: begin
            if (a_bigger) begin
               stk_wdata = '{lo: i_ff[qsort_pkg::IDX_W-1:0], hi: hi_ff};
            end else begin
               stk_wdata = '{lo: lo_ff, hi: j_ff[qsort_pkg::IDX_W-1:0]};
            end
            if (push_ok) begin
               stk_we = 1'b1;
               sp_in  = sp_ff + qsort_pkg::sp_type'(1);
            end
         end
         qsort_pkg::ST_EMIT_RD: begin
            st_raddr = k_ff;
         end
         qsort_pkg::ST_EMIT_LD: begin
            out_data_in  = st_rd_ff;
            out_valid_in = 1'b1;
         end
         qsort_pkg::ST_EMIT_OUT: begin
            if (accept_out) begin
               out_valid_in = 1'b0;
               if (out_last) begin
                  count_in = '0;
                  sp_in    = '0;
                  ovf_in   = 1'b0;
                  k_in     = '0;
               end else begin
                  k_in = k_ff + qsort_pkg::idx_type'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qsort_pkg::ST_LOAD;
         count_ff     <= '0;
         sp_ff        <= '0;
         ovf_ff       <= 1'b0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         ovf_ff       <= ovf_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      piv_ff      <= piv_in;
      jval_ff     <= jval_in;
      out_data_ff <= out_data_in;
   end

   // item store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (st_we) store[st_waddr] <= st_wdata;
      st_rd_ff <= store[st_raddr];
   end

   // range stack, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (stk_we) stack[stk_waddr] <= stk_wdata;
      stk_rd_ff <= stack[stk_raddr];
   end

   // ports
   assign req_ready        = state_ff == qsort_pkg::ST_LOAD;
   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_data_ff;
   assign rsp_last_out     = out_last;
   assign rsp_overflowed   = ovf_ff;

   // checks
   `ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready, "result pending while loading")
   `ASSERT_SAME(a_count_cap, 1'b1,
      count_ff <= qsort_pkg::cnt_type'(qsort_pkg::MAX_ITEMS), "item count past capacity")
   `ASSERT_SAME(a_scan_bounds, state_ff == qsort_pkg::ST_SCAN_I,
      (i_ff <= hi_pos) && (i_ff >= lo_pos), "scan index outside range")
   `ASSERT_NEXT(a_run_done, accept_out && rsp_last_out,
      req_ready && (count_ff == '0) && !ovf_ff, "run end did not clear")
   `ASSERT_SAME(a_stack_cap, 1'b1,
      sp_ff <= qsort_pkg::sp_type'(qsort_pkg::STACK_PAIRS), "range stack past depth")

endmodule
